>>> rtl/fbl_pkg.sv
// fbl_pkg: sizes, codes and shared structs of the free block list allocator
// depends on nothing; every other file of the block imports it

package fbl_pkg;

  localparam int CAPACITY    = 64;
  localparam int HANDLE_BITS = 32;
  localparam int SIZE_BITS   = 32;

  // slot index into the stores, and link/count width that also holds the null marker
  localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LINK_W = $clog2(CAPACITY + 1);

  localparam logic [LINK_W-1:0] NIL_LINK   = LINK_W'(CAPACITY);
  localparam logic [LINK_W-1:0] COUNT_FULL = LINK_W'(CAPACITY);

  typedef enum logic [2:0] {
    OP_PUSH       = 3'd0,
    OP_PUSH_SIZED = 3'd1,
    OP_POP        = 3'd2,
    OP_FIRST_FIT  = 3'd3,
    OP_BEST_FIT   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_WALK,
    S_UNLINK_PREV,
    S_UNLINK_FREE,
    S_RESP
  } state_t;

  // one read and one write per store per cycle
  typedef struct packed {
    logic [SLOT_W-1:0]      rd_addr;
    logic                   link_we;
    logic [SLOT_W-1:0]      link_addr;
    logic [LINK_W-1:0]      link_data;
    logic                   data_we;
    logic [SLOT_W-1:0]      data_addr;
    logic [HANDLE_BITS-1:0] data_handle;
    logic [SIZE_BITS-1:0]   data_size;
  } mem_req_t;

  // registered read data for the rd_addr of the cycle before
  typedef struct packed {
    logic [LINK_W-1:0]      link;
    logic [HANDLE_BITS-1:0] handle;
    logic [SIZE_BITS-1:0]   size;
  } mem_rsp_t;

  typedef struct packed {
    logic                   valid;
    status_t                status;
    logic [HANDLE_BITS-1:0] handle;
    logic [SIZE_BITS-1:0]   size;
  } res_t;

endpackage

>>> rtl/fbl_in_if.sv
// fbl_in_if: request channel of the allocator, valid/ready with one request per transaction
// depends on fbl_pkg

interface fbl_in_if;
  import fbl_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [2:0]             operation;
  logic [HANDLE_BITS-1:0] block_handle;
  logic [SIZE_BITS-1:0]   block_size;
  logic [SIZE_BITS-1:0]   required_size;

  modport source (
    output valid, operation, block_handle, block_size, required_size,
    input  ready
  );

  modport sink (
    input  valid, operation, block_handle, block_size, required_size,
    output ready
  );

endinterface

>>> rtl/fbl_out_if.sv
// fbl_out_if: result channel of the allocator, valid/ready with one result per transaction
// depends on fbl_pkg

interface fbl_out_if;
  import fbl_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [1:0]             status;
  logic [HANDLE_BITS-1:0] out_handle;
  logic [SIZE_BITS-1:0]   out_size;

  modport source (
    output valid, status, out_handle, out_size,
    input  ready
  );

  modport sink (
    input  valid, status, out_handle, out_size,
    output ready
  );

endinterface

>>> rtl/fbl_store.sv
// fbl_store: per-slot link, handle and size memories, synchronous registered read
// depends on fbl_pkg

module fbl_store (
  input  logic              clk,
  input  fbl_pkg::mem_req_t req,
  output fbl_pkg::mem_rsp_t rsp
);
  import fbl_pkg::*;

  logic [LINK_W-1:0]      link_mem   [CAPACITY];
  logic [HANDLE_BITS-1:0] handle_mem [CAPACITY];
  logic [SIZE_BITS-1:0]   size_mem   [CAPACITY];

  logic [LINK_W-1:0]      rd_link_r;
  logic [HANDLE_BITS-1:0] rd_handle_r;
  logic [SIZE_BITS-1:0]   rd_size_r;

  // link memory: list and free chain pointers
  always_ff @(posedge clk) begin
    if (req.link_we) begin
      link_mem[req.link_addr] <= req.link_data;
    end
    rd_link_r <= link_mem[req.rd_addr];
  end

  // block payload memories, written on push only
  always_ff @(posedge clk) begin
    if (req.data_we) begin
      handle_mem[req.data_addr] <= req.data_handle;
      size_mem[req.data_addr]   <= req.data_size;
    end
    rd_handle_r <= handle_mem[req.rd_addr];
    rd_size_r   <= size_mem[req.rd_addr];
  end

  assign rsp.link   = rd_link_r;
  assign rsp.handle = rd_handle_r;
  assign rsp.size   = rd_size_r;

endmodule

>>> rtl/fbl_seq.sv
// fbl_seq: sequencer that walks the block list through the stores and relinks slots
// depends on fbl_pkg, fbl_in_if and the registered read data of fbl_store

module fbl_seq (
  input  logic              clk,
  input  logic              rst_n,
  fbl_in_if.sink            in_chan,
  output fbl_pkg::mem_req_t mem_req,
  input  fbl_pkg::mem_rsp_t mem_rsp,
  output fbl_pkg::res_t     res,
  input  logic              res_ready
);
  import fbl_pkg::*;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  logic [HANDLE_BITS-1:0] hdl_r, hdl_nxt;
  logic [SIZE_BITS-1:0]   size_r, size_nxt;
  logic                   use_free_r, use_free_nxt;

  logic [LINK_W-1:0] list_head_r, list_head_nxt;
  logic [LINK_W-1:0] free_head_r, free_head_nxt;
  logic [LINK_W-1:0] fresh_r, fresh_nxt;
  logic [LINK_W-1:0] count_r, count_nxt;

  logic [LINK_W-1:0] node_r, node_nxt;
  logic [LINK_W-1:0] prev_r, prev_nxt;

  logic                   have_vic_r, have_vic_nxt;
  logic [LINK_W-1:0]      vic_r, vic_nxt;
  logic [LINK_W-1:0]      vic_prev_r, vic_prev_nxt;
  logic [LINK_W-1:0]      vic_link_r, vic_link_nxt;
  logic [HANDLE_BITS-1:0] vic_handle_r, vic_handle_nxt;
  logic [SIZE_BITS-1:0]   vic_size_r, vic_size_nxt;

  status_t                res_status_r, res_status_nxt;
  logic [HANDLE_BITS-1:0] res_handle_r, res_handle_nxt;
  logic [SIZE_BITS-1:0]   res_size_r, res_size_nxt;

  op_t               in_op;
  logic [SLOT_W-1:0] push_slot;
  logic              take_now;
  logic              better;

  assign in_op         = op_t'(in_chan.operation);
  assign in_chan.ready = (state_r == S_IDLE);

  // slot for a push: reuse a freed slot, else the next never-used one
  assign push_slot = use_free_r ? free_head_r[SLOT_W-1:0] : fresh_r[SLOT_W-1:0];

  // walk decisions on the entry just read
  assign take_now = (((op_r == OP_POP) || (op_r == OP_FIRST_FIT)) && (mem_rsp.size >= size_r))
                 || ((op_r == OP_BEST_FIT) && (mem_rsp.size == size_r));
  assign better   = (op_r == OP_BEST_FIT) && (mem_rsp.size > size_r)
                 && (!have_vic_r || (mem_rsp.size < vic_size_r));

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      list_head_r <= NIL_LINK;
      free_head_r <= NIL_LINK;
      fresh_r     <= '0;
      count_r     <= '0;
      have_vic_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      list_head_r <= list_head_nxt;
      free_head_r <= free_head_nxt;
      fresh_r     <= fresh_nxt;
      count_r     <= count_nxt;
      have_vic_r  <= have_vic_nxt;
    end
  end

  // transaction and walk payload
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    hdl_r        <= hdl_nxt;
    size_r       <= size_nxt;
    use_free_r   <= use_free_nxt;
    node_r       <= node_nxt;
    prev_r       <= prev_nxt;
    vic_r        <= vic_nxt;
    vic_prev_r   <= vic_prev_nxt;
    vic_link_r   <= vic_link_nxt;
    vic_handle_r <= vic_handle_nxt;
    vic_size_r   <= vic_size_nxt;
    res_status_r <= res_status_nxt;
    res_handle_r <= res_handle_nxt;
    res_size_r   <= res_size_nxt;
  end

  // next state, store accesses and result
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    hdl_nxt        = hdl_r;
    size_nxt       = size_r;
    use_free_nxt   = use_free_r;
    list_head_nxt  = list_head_r;
    free_head_nxt  = free_head_r;
    fresh_nxt      = fresh_r;
    count_nxt      = count_r;
    node_nxt       = node_r;
    prev_nxt       = prev_r;
    have_vic_nxt   = have_vic_r;
    vic_nxt        = vic_r;
    vic_prev_nxt   = vic_prev_r;
    vic_link_nxt   = vic_link_r;
    vic_handle_nxt = vic_handle_r;
    vic_size_nxt   = vic_size_r;
    res_status_nxt = res_status_r;
    res_handle_nxt = res_handle_r;
    res_size_nxt   = res_size_r;

    mem_req             = '0;
    mem_req.data_handle = hdl_r;
    mem_req.data_size   = size_r;

    res.valid  = 1'b0;
    res.status = res_status_r;
    res.handle = res_handle_r;
    res.size   = res_size_r;

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          op_nxt         = in_op;
          hdl_nxt        = in_chan.block_handle;
          res_status_nxt = ST_NONE;
          res_handle_nxt = '0;
          res_size_nxt   = '0;
          have_vic_nxt   = 1'b0;
          case (in_op)
            OP_PUSH, OP_PUSH_SIZED: begin
              size_nxt = (in_op == OP_PUSH_SIZED) ? in_chan.block_size : '0;
              if (count_r == COUNT_FULL) begin
                res_status_nxt = ST_FULL;
                state_nxt      = S_RESP;
              end else begin
                // fetch the next link of the free chain
                use_free_nxt     = (free_head_r != NIL_LINK);
                mem_req.rd_addr  = free_head_r[SLOT_W-1:0];
                state_nxt        = S_PUSH;
              end
            end
            OP_POP, OP_FIRST_FIT, OP_BEST_FIT: begin
              // pop is a first fit for size zero: the newest block
              size_nxt = (in_op == OP_POP) ? '0 : in_chan.required_size;
              if (list_head_r == NIL_LINK) begin
                state_nxt = S_RESP;
              end else begin
                node_nxt        = list_head_r;
                prev_nxt        = NIL_LINK;
                mem_req.rd_addr = list_head_r[SLOT_W-1:0];
                state_nxt       = S_WALK;
              end
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      S_PUSH: begin
        if (use_free_r) begin
          free_head_nxt = mem_rsp.link;
        end else begin
          fresh_nxt = fresh_r + 1'b1;
        end
        mem_req.link_we   = 1'b1;
        mem_req.link_addr = push_slot;
        mem_req.link_data = list_head_r;
        mem_req.data_we   = 1'b1;
        mem_req.data_addr = push_slot;
        list_head_nxt     = LINK_W'(push_slot);
        count_nxt         = count_r + 1'b1;
        res_status_nxt    = ST_OK;
        state_nxt         = S_RESP;
      end

      S_WALK: begin
        // remember the match or the best larger block so far
        if (take_now || better) begin
          have_vic_nxt   = 1'b1;
          vic_nxt        = node_r;
          vic_prev_nxt   = prev_r;
          vic_link_nxt   = mem_rsp.link;
          vic_handle_nxt = mem_rsp.handle;
          vic_size_nxt   = mem_rsp.size;
        end
        if (take_now) begin
          state_nxt = S_UNLINK_PREV;
        end else if (mem_rsp.link == NIL_LINK) begin
          state_nxt = (have_vic_r || better) ? S_UNLINK_PREV : S_RESP;
        end else begin
          prev_nxt        = node_r;
          node_nxt        = mem_rsp.link;
          mem_req.rd_addr = mem_rsp.link[SLOT_W-1:0];
        end
      end

      S_UNLINK_PREV: begin
        // bypass the chosen block; count drops with the head or link update
        if (vic_prev_r == NIL_LINK) begin
          list_head_nxt = vic_link_r;
        end else begin
          mem_req.link_we   = 1'b1;
          mem_req.link_addr = vic_prev_r[SLOT_W-1:0];
          mem_req.link_data = vic_link_r;
        end
        count_nxt = count_r - 1'b1;
        state_nxt = S_UNLINK_FREE;
      end

      S_UNLINK_FREE: begin
        // return the slot to the free chain
        mem_req.link_we   = 1'b1;
        mem_req.link_addr = vic_r[SLOT_W-1:0];
        mem_req.link_data = free_head_r;
        free_head_nxt     = vic_r;
        res_status_nxt    = ST_OK;
        res_handle_nxt    = vic_handle_r;
        res_size_nxt      = vic_size_r;
        state_nxt         = S_RESP;
      end

      S_RESP: begin
        res.valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // list bookkeeping stays consistent
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_FULL)
    else $error("block count above capacity");

  a_head_vs_count: assert property (@(posedge clk) disable iff (!rst_n)
    (list_head_r == NIL_LINK) == (count_r == '0))
    else $error("list head and block count disagree");

  a_walk_node: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (node_r != NIL_LINK))
    else $error("walk on null slot");

  a_fresh_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH && !use_free_r) |-> (fresh_r < COUNT_FULL))
    else $error("no unused slot left for push");

  a_resp_done: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res_ready) |=> (state_r == S_IDLE))
    else $error("sequencer did not return to idle after result");

endmodule

>>> rtl/free_block_list_fit.sv
// free_block_list_fit: top level of the free block list allocator
// depends on fbl_pkg, fbl_in_if, fbl_out_if, fbl_store and fbl_seq
//
//  channel    | direction | transaction
//  -----------+-----------+---------------------------------------------------
//  in_chan    | sink      | operation, block_handle, block_size, required_size
//  out_chan   | source    | status, out_handle, out_size (one per request)
//
// push passes S_PUSH; pop, first fit and best fit walk the list in S_WALK,
// one block per cycle up to 64 blocks, and unlink the chosen block in
// S_UNLINK_PREV, then S_UNLINK_FREE; empty list, full list or unknown operation
// go straight to S_RESP; reset is synchronous; the list comes up empty, memories are not cleared
// a stalled result holds in the output register; the next request is still
// taken and its result waits in the sequencer until the register frees

module free_block_list_fit (
  input  logic clk,
  input  logic rst_n,
  fbl_in_if.sink    in_chan,
  fbl_out_if.source out_chan
);
  import fbl_pkg::*;

  mem_req_t mem_req;
  mem_rsp_t mem_rsp;
  res_t     res;
  logic     res_ready;

  logic                   out_valid_r;
  status_t                out_status_r;
  logic [HANDLE_BITS-1:0] out_handle_r;
  logic [SIZE_BITS-1:0]   out_size_r;

  fbl_store u_store (
    .clk (clk),
    .req (mem_req),
    .rsp (mem_rsp)
  );

  fbl_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .mem_req   (mem_req),
    .mem_rsp   (mem_rsp),
    .res       (res),
    .res_ready (res_ready)
  );

  // output register takes a new result once the old one is gone
  assign res_ready = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      out_status_r <= res.status;
      out_handle_r <= res.handle;
      out_size_r   <= res.size;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.status     = out_status_r;
  assign out_chan.out_handle = out_handle_r;
  assign out_chan.out_size   = out_size_r;

endmodule

>>> tb/sv/tb_top.sv
// tb_top: self-checking testbench for the free block list allocator
// depends on fbl_pkg, fbl_in_if, fbl_out_if and free_block_list_fit
// requests are predicted against a shadow list; responses are checked in order

module tb_top;
  import fbl_pkg::*;

  localparam logic [2:0] OP_CODE_MAX  = 3'd7;
  localparam int         QUIET_LIMIT  = 3000;
  localparam int         DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [HANDLE_BITS-1:0] handle;
    logic [SIZE_BITS-1:0]   size;
  } free_block_t;

  typedef struct packed {
    status_t                status;
    logic [HANDLE_BITS-1:0] handle;
    logic [SIZE_BITS-1:0]   size;
  } alloc_answer_t;

  logic clk;
  logic rst_n;

  fbl_in_if  in_chan ();
  fbl_out_if out_chan ();

  free_block_list_fit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // shadow of the free list, newest block at index 0
  free_block_t   free_blocks[$];
  alloc_answer_t answers_due[$];

  int src_idle_pct  = 0;
  int sink_stall_pct = 0;
  int error_count   = 0;
  int n_requests    = 0;
  int n_responses   = 0;
  int n_full        = 0;
  int n_none        = 0;
  int deepest_list  = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // shadow list update for one accepted request, returns the answer due
  function automatic alloc_answer_t apply_list_op(input logic [2:0] op,
                                                  input logic [HANDLE_BITS-1:0] handle,
                                                  input logic [SIZE_BITS-1:0] size,
                                                  input logic [SIZE_BITS-1:0] need);
    alloc_answer_t ans;
    free_block_t   blk;
    int            pick;
    int            larger;
    int            i;
    ans    = '{status: ST_NONE, handle: '0, size: '0};
    pick   = -1;
    larger = -1;
    case (op)
      OP_PUSH, OP_PUSH_SIZED: begin
        if (free_blocks.size() >= CAPACITY) begin
          ans.status = ST_FULL;
        end else begin
          blk.handle = handle;
          blk.size   = (op == OP_PUSH_SIZED) ? size : '0;
          free_blocks.push_front(blk);
          ans.status = ST_OK;
        end
      end
      OP_POP: begin
        if (free_blocks.size() != 0) pick = 0;
      end
      OP_FIRST_FIT: begin
        for (i = 0; i < free_blocks.size() && pick < 0; i++) begin
          if (free_blocks[i].size >= need) pick = i;
        end
      end
      OP_BEST_FIT: begin
        // exact size wins; else smallest larger, newest on a tie
        for (i = 0; i < free_blocks.size() && pick < 0; i++) begin
          if (free_blocks[i].size == need) begin
            pick = i;
          end else if (free_blocks[i].size > need &&
                       (larger < 0 || free_blocks[i].size < free_blocks[larger].size)) begin
            larger = i;
          end
        end
        if (pick < 0) pick = larger;
      end
      default: ;
    endcase
    if (pick >= 0) begin
      ans.status = ST_OK;
      ans.handle = free_blocks[pick].handle;
      ans.size   = free_blocks[pick].size;
      free_blocks.delete(pick);
    end
    if (ans.status == ST_FULL) n_full++;
    if (ans.status == ST_NONE) n_none++;
    if (free_blocks.size() > deepest_list) deepest_list = free_blocks.size();
    return ans;
  endfunction

  // one request transaction, with random idle cycles ahead of it
  task automatic send_request(input logic [2:0] op,
                              input logic [HANDLE_BITS-1:0] handle,
                              input logic [SIZE_BITS-1:0] size,
                              input logic [SIZE_BITS-1:0] need);
    while ($urandom_range(99) < src_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.operation     <= op;
    in_chan.block_handle  <= handle;
    in_chan.block_size    <= size;
    in_chan.required_size <= need;
    do @(posedge clk); while (!in_chan.ready);
    answers_due.push_back(apply_list_op(op, handle, size, need));
    n_requests++;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got %0h wanted %0h", $time, what, got, want);
    error_count++;
  endtask

  task automatic check_response();
    alloc_answer_t want;
    n_responses++;
    if (answers_due.size() == 0) begin
      report_mismatch("response with no request outstanding, status", out_chan.status, '0);
      return;
    end
    want = answers_due.pop_front();
    if (out_chan.status !== want.status)
      report_mismatch("status", out_chan.status, want.status);
    if (out_chan.out_handle !== want.handle)
      report_mismatch("out_handle", out_chan.out_handle, want.handle);
    if (out_chan.out_size !== want.size)
      report_mismatch("out_size", out_chan.out_size, want.size);
  endtask

  // response side: check each transaction, then pick the next ready level
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) check_response();
    out_chan.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // watchdog on cycles without any transaction
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: %0d cycles without a transaction, %0d responses outstanding",
             quiet, answers_due.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // sizes: mostly small so exact hits and ties happen, plus the extremes
  function automatic logic [SIZE_BITS-1:0] rand_size();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return SIZE_BITS'($urandom_range(15));
      6:                return SIZE_BITS'($urandom);
      7:                return ~SIZE_BITS'($urandom_range(15));
      8:                return '0;
      default:          return SIZE_BITS'($urandom_range(255));
    endcase
  endfunction

  // required size, often near a size that is on the list
  function automatic logic [SIZE_BITS-1:0] rand_required();
    logic [SIZE_BITS-1:0] v;
    if (free_blocks.size() != 0 && $urandom_range(99) < 40) begin
      v = free_blocks[$urandom_range(free_blocks.size() - 1)].size;
      case ($urandom_range(2))
        0:       return v;
        1:       return v - 1'b1;
        default: return v + 1'b1;
      endcase
    end
    return rand_size();
  endfunction

  function automatic logic [2:0] pick_op(input int push_pct);
    int roll;
    if ($urandom_range(99) < 4) return 3'($urandom_range(OP_BEST_FIT + 1, OP_CODE_MAX));
    if ($urandom_range(99) < push_pct)
      return ($urandom_range(3) == 0) ? OP_PUSH : OP_PUSH_SIZED;
    roll = $urandom_range(99);
    if (roll < 25) return OP_POP;
    if (roll < 60) return OP_FIRST_FIT;
    return OP_BEST_FIT;
  endfunction

  task automatic send_random(input int push_pct);
    send_request(pick_op(push_pct), HANDLE_BITS'($urandom), rand_size(), rand_required());
  endtask

  // removals and unknown codes on an empty list
  task automatic test_empty_list();
    send_request(OP_POP, $urandom, $urandom, $urandom);
    send_request(OP_FIRST_FIT, $urandom, $urandom, '0);
    send_request(OP_BEST_FIT, $urandom, $urandom, '0);
    send_request(OP_BEST_FIT + 3'd1, $urandom, $urandom, $urandom);
    send_request(OP_CODE_MAX - 3'd1, $urandom, $urandom, $urandom);
    send_request(OP_CODE_MAX, '1, '1, '1);
  endtask

  // extreme handles and sizes, plain push records size zero
  task automatic test_push_extremes();
    send_request(OP_PUSH, '0, '1, $urandom);
    send_request(OP_PUSH_SIZED, '1, '1, $urandom);
    send_request(OP_PUSH_SIZED, HANDLE_BITS'(32'h5a5a_a5a5), '0, $urandom);
    send_request(OP_BEST_FIT, $urandom, $urandom, '1);
    send_request(OP_FIRST_FIT, $urandom, $urandom, '0);
    send_request(OP_POP, $urandom, $urandom, $urandom);
  endtask

  // first fit and best fit choices: ties, exact behind larger, middle removal
  task automatic test_fit_choice();
    send_request(OP_PUSH_SIZED, 32'ha, 32'd8, $urandom);
    send_request(OP_PUSH_SIZED, 32'hb, 32'd20, $urandom);
    send_request(OP_PUSH_SIZED, 32'hc, 32'd12, $urandom);
    send_request(OP_PUSH_SIZED, 32'hd, 32'd20, $urandom);
    send_request(OP_PUSH_SIZED, 32'he, 32'd12, $urandom);
    send_request(OP_BEST_FIT, $urandom, $urandom, 32'd10);
    send_request(OP_BEST_FIT, $urandom, $urandom, 32'd12);
    send_request(OP_PUSH_SIZED, 32'hf, 32'd5, $urandom);
    send_request(OP_FIRST_FIT, $urandom, $urandom, 32'd6);
    send_request(OP_BEST_FIT, $urandom, $urandom, 32'd25);
    send_request(OP_FIRST_FIT, $urandom, $urandom, '0);
    send_request(OP_BEST_FIT, $urandom, $urandom, 32'd9);
    send_request(OP_POP, $urandom, $urandom, $urandom);
  endtask

  // fill to capacity, push into the full list, then drain it
  task automatic test_full_list();
    src_idle_pct   = 35;
    sink_stall_pct = 35;
    while (free_blocks.size() < CAPACITY)
      send_request(($urandom_range(3) == 0) ? OP_PUSH : OP_PUSH_SIZED,
                   $urandom, rand_size(), $urandom);
    send_request(OP_PUSH, $urandom, $urandom, $urandom);
    send_request(OP_PUSH_SIZED, $urandom, $urandom, $urandom);
    while (free_blocks.size() != 0)
      send_random(0);
    send_request(OP_POP, $urandom, $urandom, $urandom);
  endtask

  // random traffic under each idling pattern, alternating fill and drain
  task automatic test_random_traffic();
    int src_pct[4];
    int sink_pct[4];
    int ph;
    int i;
    src_pct  = '{0, 70, 0, 35};
    sink_pct = '{0, 0, 70, 35};
    for (ph = 0; ph < 4; ph++) begin
      src_idle_pct   = src_pct[ph];
      sink_stall_pct = sink_pct[ph];
      for (i = 0; i < 200; i++)
        send_random(((i / 40) % 2 == 0) ? 70 : 30);
    end
  endtask

  // reset, tests, drain and verdict
  initial begin
    rst_n                 <= 1'b0;
    in_chan.valid         <= 1'b0;
    in_chan.operation     <= OP_PUSH;
    in_chan.block_handle  <= '0;
    in_chan.block_size    <= '0;
    in_chan.required_size <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_push_extremes();
    test_fit_choice();
    test_full_list();
    test_random_traffic();

    in_chan.valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests and %0d responses, list depth up to %0d",
             n_requests, n_responses, deepest_list);
    $display("answers: %0d full-list, %0d empty or no fit", n_full, n_none);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
